// File: sv/msr_pkg.sv
// msr_pkg: widths, codes, types and helpers shared by the reduction block
// no dependencies; imported by every module of the block
`default_nettype none

package msr_pkg;

    localparam int VALUE_W    = 32;          // q16.16 value width
    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = 40;          // accumulator width
    localparam int ALU_W      = ACC_W + 1;   // shared unit width, one guard bit
    localparam int CNT_W      = 8;           // source count width
    localparam int IDX_W      = 16;          // element index and address width
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = ACC_W;       // one quotient bit per cycle
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // reduction codes
    localparam logic [OP_W-1:0] OP_UNSPEC = 3'd0;
    localparam logic [OP_W-1:0] OP_SUM    = 3'd1;
    localparam logic [OP_W-1:0] OP_MAX    = 3'd2;
    localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
    localparam logic [OP_W-1:0] OP_MEAN   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEGREE = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_UNSPEC = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSRC  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] src_count;
        logic [IDX_W-1:0] elem_count;
        logic [IDX_W-1:0] base;
    } t_cfg;

    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } t_alu_req;

    // saturate a wide signed value to the value range
    function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [ALU_W-1:0] x);
        logic [ALU_W-VALUE_W:0] top;
        top = x[ALU_W-1:VALUE_W-1];
        if ((&top) || !(|top)) begin
            sat_val = x[VALUE_W-1:0];
        end else if (x[ALU_W-1]) begin
            sat_val = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/msr_in_if.sv
// msr_in_if: request channel carrying one source value per request
// depends on msr_pkg for the value width
`default_nettype none

interface msr_in_if
    import msr_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] current_value;
    logic signed [VALUE_W-1:0] previous_value;
    logic                      use_current;

    modport source (output valid, output current_value, output previous_value,
                    output use_current, input ready);
    modport sink   (input valid, input current_value, input previous_value,
                    input use_current, output ready);
endinterface

`default_nettype wire

// File: sv/msr_out_if.sv
// msr_out_if: result channel, one reduced element per closed element
// depends on msr_pkg for widths
`default_nettype none

interface msr_out_if
    import msr_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_value;
    logic [IDX_W-1:0]          target_address;
    logic [ST_W-1:0]           status;
    logic                      last_element;

    modport source (output valid, output result_value, output target_address,
                    output status, output last_element, input ready);
    modport sink   (input valid, input result_value, input target_address,
                    input status, input last_element, output ready);
endinterface

`default_nettype wire

// File: sv/multi_source_reduction.sv
// a zero-source request goes from idle straight to the emit state; any other request
// passes the accumulate state, then the emit state if it closes a sum, max, min, degree
// or error element; a closing mean runs negate, 40 divide steps and a sign step
// on the shared add / subtract unit first; a new request is taken only in the idle state
// a result waiting downstream keeps the sequencer in its emit state, stalling the input
// synchronous active-low reset clears counters, accumulator and output valid
`default_nettype none

module multi_source_reduction
    import msr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    msr_in_if.sink                     i_in,
    msr_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // configuration, held until rewritten; writes never touch the counters
    t_cfg                    cfg;

    // request and answer of the shared arithmetic unit
    t_alu_req                alu_req;
    logic signed [ALU_W-1:0] alu_y;

    msr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // one adder serves accumulation, max / min compares, negation and the
    // restoring division for the mean
    msr_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    // sequencer owns the element state and the output register, so the next
    // request is taken while a finished result still waits downstream
    msr_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_alu_req (alu_req),
        .i_alu_y   (alu_y)
    );

endmodule

`default_nettype wire

// File: sv/msr_regs.sv
// msr_regs: configuration register file, write only
// depends on msr_pkg
`default_nettype none

module msr_regs
    import msr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op         <= OP_UNSPEC;
            r_cfg.src_count  <= '0;
            r_cfg.elem_count <= IDX_W'(1);
            r_cfg.base       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OP:   r_cfg.op         <= i_cfg_wdata[OP_W-1:0];
                CFG_SRC:  r_cfg.src_count  <= i_cfg_wdata[CNT_W-1:0];
                CFG_ELEM: r_cfg.elem_count <= i_cfg_wdata[IDX_W-1:0];
                CFG_BASE: r_cfg.base       <= i_cfg_wdata[IDX_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/msr_alu.sv
// msr_alu: shared add / subtract unit used for accumulate, compare and divide
// depends on msr_pkg
`default_nettype none

module msr_alu
    import msr_pkg::*;
(
    input  t_alu_req                       i_req,
    output logic signed [ALU_W-1:0]        o_y
);

    always_comb begin
        if (i_req.sub) begin
            o_y = i_req.a - i_req.b;
        end else begin
            o_y = i_req.a + i_req.b;
        end
    end

endmodule

`default_nettype wire

// File: sv/msr_seq.sv
// msr_seq: sequencer, accumulator, restoring divider steps and output register
// depends on msr_pkg, msr_in_if, msr_out_if; drives the shared msr_alu
`default_nettype none

module msr_seq
    import msr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_cfg                    i_cfg,
    msr_in_if.sink                  i_in,
    msr_out_if.source               o_out,
    output t_alu_req                o_alu_req,
    input  wire logic signed [ALU_W-1:0] i_alu_y
);

    typedef enum logic [2:0] {
        S_IDLE, S_ACC, S_NEG, S_DIV, S_SIGN, S_EMIT
    } t_state;

    t_state                    r_state;
    logic signed [VALUE_W-1:0] r_val;
    logic [CNT_W-1:0]          r_n;
    logic [OP_W-1:0]           r_op;
    logic signed [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]          r_seen;
    logic [IDX_W-1:0]          r_idx;
    logic signed [VALUE_W-1:0] r_res;
    logic [ST_W-1:0]           r_status;
    logic [CNT_W-1:0]          r_rem;
    logic [ACC_W-1:0]          r_quo;
    logic                      r_neg;
    logic [DIV_CNT_W-1:0]      r_cnt;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [IDX_W-1:0]          r_out_addr;
    logic [ST_W-1:0]           r_out_status;
    logic                      r_out_last;

    logic                      first;
    logic [CNT_W:0]            seen_inc;
    logic                      elem_done;
    logic signed [ACC_W-1:0]   acc_new;
    logic [CNT_W:0]            partial;
    logic [OP_W-1:0]           op_in;
    logic                      out_free;
    logic                      last;
    logic signed [ALU_W-1:0]   quo_signed;

    assign first     = (r_seen == '0);
    assign seen_inc  = {1'b0, r_seen} + (CNT_W+1)'(1);
    assign elem_done = (seen_inc >= {1'b0, r_n});
    assign partial   = {r_rem, r_quo[ACC_W-1]};
    assign op_in     = (i_cfg.op > OP_DEGREE) ? OP_UNSPEC : i_cfg.op;
    assign out_free  = !r_out_valid || o_out.ready;
    assign last      = (r_idx == (i_cfg.elem_count - IDX_W'(1)));
    assign quo_signed = r_neg ? i_alu_y : {1'b0, r_quo};

    // operand selection for the shared unit
    always_comb begin
        o_alu_req.a   = '0;
        o_alu_req.b   = '0;
        o_alu_req.sub = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_alu_req.a   = ALU_W'(r_acc);
                o_alu_req.b   = ALU_W'(r_val);
                o_alu_req.sub = (r_op == OP_MAX) || (r_op == OP_MIN);
            end
            S_NEG: begin
                o_alu_req.b   = ALU_W'(r_acc);
                o_alu_req.sub = 1'b1;
            end
            S_DIV: begin
                o_alu_req.a   = {{(ALU_W-CNT_W-1){1'b0}}, partial};
                o_alu_req.b   = {{(ALU_W-CNT_W){1'b0}}, r_n};
                o_alu_req.sub = 1'b1;
            end
            S_SIGN: begin
                o_alu_req.b   = {1'b0, r_quo};
                o_alu_req.sub = 1'b1;
            end
            S_IDLE, S_EMIT: begin
            end
        endcase
    end

    // next accumulator value for the current request
    always_comb begin
        priority case (r_op)
            OP_SUM, OP_MEAN: acc_new = first ? ACC_W'(r_val) : i_alu_y[ACC_W-1:0];
            // acc - v negative means v is larger
            OP_MAX: acc_new = (first || i_alu_y[ALU_W-1]) ? ACC_W'(r_val) : r_acc;
            OP_MIN: acc_new = (first || (!i_alu_y[ALU_W-1] && (i_alu_y != '0)))
                              ? ACC_W'(r_val) : r_acc;
            default: acc_new = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_seen      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_val <= i_in.use_current ? i_in.current_value : i_in.previous_value;
                        r_n   <= i_cfg.src_count;
                        r_op  <= op_in;
                        if (i_cfg.src_count == '0) begin
                            // no sources: answer at once, value ignored
                            r_res  <= '0;
                            r_acc  <= '0;
                            r_seen <= '0;
                            if (op_in == OP_UNSPEC) begin
                                r_status <= ST_UNSPEC;
                            end else if ((op_in == OP_MAX) || (op_in == OP_MIN) ||
                                         (op_in == OP_MEAN)) begin
                                r_status <= ST_NOSRC;
                            end else begin
                                r_status <= ST_OK;
                            end
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (!elem_done) begin
                        r_acc   <= acc_new;
                        r_seen  <= seen_inc[CNT_W-1:0];
                        r_state <= S_IDLE;
                    end else begin
                        // mean keeps the sum for the divider, the rest emit now
                        r_seen   <= '0;
                        r_acc    <= (r_op == OP_MEAN) ? acc_new : '0;
                        r_state  <= (r_op == OP_MEAN) ? S_NEG : S_EMIT;
                        r_status <= (r_op == OP_UNSPEC) ? ST_UNSPEC : ST_OK;
                        priority case (r_op)
                            OP_SUM:         r_res <= sat_val(ALU_W'(acc_new));
                            OP_MAX, OP_MIN: r_res <= acc_new[VALUE_W-1:0];
                            OP_DEGREE: begin
                                r_res <= {{(VALUE_W-CNT_W-FRAC_BITS){1'b0}}, r_n,
                                          {FRAC_BITS{1'b0}}};
                            end
                            // mean value comes from the divider later
                            default:        r_res <= '0;
                        endcase
                    end
                end
                S_NEG: begin
                    // divide the magnitude, fix the sign at the end
                    r_neg   <= r_acc[ACC_W-1];
                    r_quo   <= r_acc[ACC_W-1] ? i_alu_y[ACC_W-1:0] : r_acc;
                    r_rem   <= '0;
                    r_cnt   <= DIV_CNT_W'(DIV_STEPS - 1);
                    r_acc   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!i_alu_y[ALU_W-1]) begin
                        r_rem <= i_alu_y[CNT_W-1:0];
                        r_quo <= {r_quo[ACC_W-2:0], 1'b1};
                    end else begin
                        r_rem <= partial[CNT_W-1:0];
                        r_quo <= {r_quo[ACC_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    r_res   <= sat_val(quo_signed);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_value  <= r_res;
                        r_out_addr   <= i_cfg.base + r_idx;
                        r_out_status <= r_status;
                        r_out_last   <= last;
                        r_idx        <= last ? '0 : r_idx + IDX_W'(1);
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.result_value   = r_out_value;
    assign o_out.target_address = r_out_addr;
    assign o_out.status         = r_out_status;
    assign o_out.last_element   = r_out_last;

endmodule

`default_nettype wire

// File: sv/msr_checker.sv
// msr_checker: port-level checks on the reduction block, bound to the top level
// depends on msr_pkg and multi_source_reduction
`default_nettype none

module msr_checker
    import msr_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic signed [VALUE_W-1:0] i_out_value,
    input wire logic [ST_W-1:0]           i_out_status
);

    // one request at a time: busy right after taking one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready straight after a request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result dropped or changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_OK) || (i_out_status == ST_UNSPEC) ||
                        (i_out_status == ST_NOSRC))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> (i_out_value == '0))
        else $error("error result carries a value");

endmodule

bind multi_source_reduction msr_checker u_msr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.result_value),
    .i_out_status (o_out.status)
);

`default_nettype wire

// File: sim/tb_multi_source_reduction.sv
// tb_multi_source_reduction: self-checking bench for the multi-source reduction block
// drives the request channel and the register port, predicts every reduced element
// depends on msr_pkg, msr_in_if, msr_out_if and multi_source_reduction
`timescale 1ns / 100ps

module tb_multi_source_reduction;
    import msr_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    // the mean divide is the slowest element
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 12;

    // selector codes above degree have no name in the package
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // idling per pace: none, sender only, receiver only, both lightly
    localparam int TX_IDLE[4]  = '{0, 49, 0, 7};
    localparam int RX_STALL[4] = '{0, 0, 49, 7};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          address;
        logic [ST_W-1:0]           status;
        logic                      last;
    } t_element;

    // running reduction of the current element plus the queue of elements still owed
    class t_scoreboard;
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] src_count;
        logic [IDX_W-1:0] elem_count;
        logic [IDX_W-1:0] base;
        longint           acc;
        logic [CNT_W-1:0] seen;
        logic [IDX_W-1:0] elem_idx;
        t_element         expected_elements[$];
        int               errors;

        function new();
            op         = OP_UNSPEC;
            src_count  = '0;
            elem_count = 16'd1;
            base       = '0;
            acc        = 0;
            seen       = '0;
            elem_idx   = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OP:   op         = data[OP_W-1:0];
                CFG_SRC:  src_count  = data[CNT_W-1:0];
                CFG_ELEM: elem_count = data[IDX_W-1:0];
                CFG_BASE: base       = data[IDX_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_q(longint x);
            if (x > Q_MAX) return Q_MAX;
            if (x < Q_MIN) return Q_MIN;
            return x;
        endfunction

        function int pending();
            return expected_elements.size();
        endfunction

        function void take_value(logic signed [VALUE_W-1:0] cur,
                                 logic signed [VALUE_W-1:0] prev, logic use_cur);
            logic [OP_W-1:0]  eff_op;
            logic [IDX_W-1:0] last_idx;
            longint           v;
            longint           res;
            logic [ST_W-1:0]  st;
            bit               first;
            t_element         elem;
            eff_op = (op > OP_DEGREE) ? OP_UNSPEC : op;
            res    = 0;
            st     = ST_OK;
            if (src_count == 0) begin
                // every request closes an element, its value unused
                if (eff_op == OP_UNSPEC) begin
                    st = ST_UNSPEC;
                end else if (eff_op == OP_MAX || eff_op == OP_MIN || eff_op == OP_MEAN) begin
                    st = ST_NOSRC;
                end
                acc  = 0;
                seen = '0;
            end else begin
                v     = use_cur ? cur : prev;
                first = (seen == 0);
                case (eff_op)
                    OP_SUM, OP_MEAN: acc = first ? v : acc + v;
                    OP_MAX:          if (first || v > acc) acc = v;
                    OP_MIN:          if (first || v < acc) acc = v;
                    default:         acc = 0;
                endcase
                seen = seen + 1'b1;
                if (seen < src_count && seen != 0) return;
                case (eff_op)
                    OP_SUM:         res = clamp_q(acc);
                    OP_MAX, OP_MIN: res = acc;
                    OP_MEAN:        res = clamp_q(acc / longint'(src_count));
                    OP_DEGREE:      res = clamp_q(longint'(src_count) << FRAC_BITS);
                    default:        st  = ST_UNSPEC;
                endcase
                acc  = 0;
                seen = '0;
            end
            last_idx     = elem_count - 1'b1;
            elem.value   = res[VALUE_W-1:0];
            elem.address = base + elem_idx;
            elem.status  = st;
            elem.last    = (elem_idx == last_idx);
            elem_idx     = elem.last ? '0 : elem_idx + 1'b1;
            expected_elements.push_back(elem);
        endfunction

        function void match_element(t_element got);
            t_element want;
            if (expected_elements.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected element: value %h address %h status %0d last %0b",
                             got.value, got.address, got.status, got.last);
                end
                return;
            end
            want = expected_elements.pop_front();
            if (got.value !== want.value || got.address !== want.address ||
                got.status !== want.status || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("element mismatch: expected value %h address %h status %0d last %0b",
                             want.value, want.address, want.status, want.last);
                    $display("                  actual   value %h address %h status %0d last %0b",
                             got.value, got.address, got.status, got.last);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    msr_in_if  in_ch ();
    msr_out_if out_ch ();

    multi_source_reduction dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    t_scoreboard reducer;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_ticket;   // bumped by the stimulus to ask for one long receiver hold-off
    int hold_served;
    int hold_left;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // receiver: ready changes on the falling edge, random stalls or a long hold-off
    always @(negedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // monitor: register writes, results and requests seen at the rising edge, in that order,
    // so that a result is always matched before the request of the same edge is noted
    always @(posedge i_clk) begin : monitor
        t_element got;
        if (i_rst_n) begin
            if (cfg_we) begin
                reducer.set_reg(cfg_index, cfg_wdata);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.value   = out_ch.result_value;
                got.address = out_ch.target_address;
                got.status  = out_ch.status;
                got.last    = out_ch.last_element;
                reducer.match_element(got);
            end
            if (in_ch.valid && in_ch.ready) begin
                reducer.take_value(in_ch.current_value, in_ch.previous_value,
                                   in_ch.use_current);
            end
        end
        // watchdog: cycles with no request moving on either channel
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one register write; starts on the next falling edge, ends on a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // writes all four registers; the unused upper bits of op and count carry junk
    task automatic configure(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] src,
                             input logic [IDX_W-1:0] elem, input logic [IDX_W-1:0] base);
        logic [CFG_DATA_W-OP_W-1:0]  op_junk;
        logic [CFG_DATA_W-CNT_W-1:0] src_junk;
        op_junk  = (CFG_DATA_W-OP_W)'($urandom);
        src_junk = (CFG_DATA_W-CNT_W)'($urandom);
        write_reg(CFG_OP, {op_junk, op});
        write_reg(CFG_SRC, {src_junk, src});
        write_reg(CFG_ELEM, elem);
        write_reg(CFG_BASE, base);
    endtask

    task automatic set_pace(input int mode);
        tx_idle_pct = TX_IDLE[mode];
        rx_stall_pct <= RX_STALL[mode];
    endtask

    // one request: value goes to the selected copy, the other copy is random;
    // entered and left on a falling edge, valid left high for a following request
    task automatic offer_value(input logic signed [VALUE_W-1:0] value, input logic use_cur);
        logic signed [VALUE_W-1:0] other;
        other = $urandom;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid          <= 1'b0;
            in_ch.current_value  <= $urandom;
            in_ch.previous_value <= $urandom;
            in_ch.use_current    <= 1'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.use_current    <= use_cur;
        in_ch.current_value  <= use_cur ? value : other;
        in_ch.previous_value <= use_cur ? other : value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every owed element, then let a busy divide run out
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (reducer.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // extremes, special values and small numbers around zero, with plain random ones
    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] x;
        x = $urandom_range(0, 1 << 20);
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return x - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [OP_W-1:0]  nosrc_ops[4];
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] src;
        logic [IDX_W-1:0] elem;
        logic [IDX_W-1:0] base;
        int               n_items;
        int               r;

        reducer              = new();
        nosrc_ops            = '{OP_MAX, OP_MIN, OP_MEAN, OP_DEGREE};
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_wdata            = '0;
        in_ch.valid          = 1'b0;
        in_ch.current_value  = '0;
        in_ch.previous_value = '0;
        in_ch.use_current    = 1'b0;
        out_ch.ready         = 1'b0;
        tx_idle_pct          = 0;
        rx_stall_pct         = 0;
        hold_ticket          = 0;
        hold_served          = 0;
        hold_left            = 0;
        idle_cycles          = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // reset settings: unspecified op and no sources, each request is its own element
        offer_value(VAL_MAX, 1'b1);
        offer_value(VAL_MIN, 1'b0);
        settle();

        // no sources with sum: zero, ok status, address wraps past the top
        configure(OP_SUM, 8'd0, 16'd3, 16'hFFFE);
        repeat (3) offer_value(random_value(), 1'($urandom));
        settle();

        // no sources with max, min and mean flag the error, degree reads zero
        for (int k = 0; k < 4; k++) begin
            configure(nosrc_ops[k], 8'd0, 16'd1, 16'h0100);
            offer_value(random_value(), 1'($urandom));
            settle();
        end

        // sum saturates at both ends, each element using the current copy then the previous one
        configure(OP_SUM, 8'd2, 16'd4, 16'h1234);
        offer_value(VAL_MAX, 1'b1);
        offer_value(VAL_MAX, 1'b0);
        offer_value(VAL_MIN, 1'b1);
        offer_value(VAL_MIN, 1'b0);
        settle();

        configure(OP_MAX, 8'd3, 16'd2, 16'h8000);
        offer_value('1, 1'b1);
        offer_value(VAL_MIN, 1'b0);
        offer_value(32'sd5, 1'b1);
        settle();

        configure(OP_MIN, 8'd3, 16'd2, 16'h8000);
        offer_value(32'sd7, 1'b0);
        offer_value(VAL_MAX, 1'b1);
        offer_value(-32'sd3, 1'b0);
        settle();

        // mean of a negative sum truncates toward zero
        configure(OP_MEAN, 8'd3, 16'd5, 16'h0040);
        offer_value(-32'sd7, 1'b1);
        offer_value('0, 1'b0);
        offer_value('0, 1'b1);
        settle();

        configure(OP_DEGREE, 8'd2, 16'd5, 16'h0040);
        offer_value(random_value(), 1'b1);
        offer_value(random_value(), 1'b0);
        settle();

        // selector above degree behaves as unspecified
        configure(OP_SPARE_LO, 8'd2, 16'd5, 16'h0040);
        offer_value(random_value(), 1'b1);
        offer_value(random_value(), 1'b0);
        settle();

        // count lowered mid-element: the next request closes it
        configure(OP_SUM, 8'd4, 16'd5, 16'h0040);
        repeat (3) offer_value(random_value(), 1'($urandom));
        settle();
        configure(OP_SUM, 8'd2, 16'd5, 16'h0040);
        offer_value(random_value(), 1'($urandom));
        settle();

        // ---- random part ----
        // phases rarely end on an element boundary, so later phases also change the
        // count while an element is half done
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_pace(phase % 4);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                op = OP_W'($urandom_range(OP_SUM, OP_DEGREE));
            end else if (r == 7) begin
                op = OP_UNSPEC;
            end else if (r == 8) begin
                op = OP_SPARE_LO;
            end else begin
                op = OP_SPARE_HI;
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                src = '0;
            end else if (r == 1) begin
                src = CNT_W'($urandom_range(8, 40));
            end else begin
                src = CNT_W'($urandom_range(1, 6));
            end
            case ($urandom_range(0, 7))
                0:       elem = '0;
                1:       elem = '1;
                default: elem = IDX_W'($urandom_range(1, 6));
            endcase
            base    = ($urandom_range(0, 7) == 0) ? '1 : IDX_W'($urandom);
            n_items = $urandom_range(15, 30);
            if (phase == 0) begin
                // the largest count: one long element feeding the divider
                op      = OP_MEAN;
                src     = '1;
                n_items = 255 + $urandom_range(0, 10);
            end
            if (phase == 3) begin
                // one result per request so the long hold-off backs up the input
                src = 8'd1;
            end
            configure(op, src, elem, base);
            if (phase == 3) begin
                hold_ticket <= hold_ticket + 1;
            end
            for (int i = 0; i < n_items; i++) begin
                if (phase == 6 && i == n_items / 2) begin
                    // sender waits here until every owed element has come out
                    in_ch.valid <= 1'b0;
                    @(negedge i_clk);
                    while (reducer.pending() != 0) @(negedge i_clk);
                end
                offer_value(random_value(), 1'($urandom));
            end
            settle();
        end

        // ---- index past the count ----
        // element count of zero acts as 65536; lowering it to one then leaves the index
        // past the end, so it keeps counting up and no element is marked last
        set_pace(0);
        configure(OP_SUM, 8'd0, 16'd0, IDX_W'($urandom));
        repeat (3) offer_value(random_value(), 1'($urandom));
        settle();
        configure(OP_SUM, 8'd0, 16'd1, IDX_W'($urandom));
        repeat (5) offer_value(random_value(), 1'($urandom));
        settle();

        if (reducer.errors == 0 && reducer.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
